>>> hw/rtl/crast_pkg.sv
// ----------------------------------------------------------------------------
// crast_pkg
// Shared constants, types and the octant select table for the circle
// rasterizer.
// ----------------------------------------------------------------------------
package crast_pkg;

	// Default geometry
	localparam int COORD_BITS_DEF  = 12;
	localparam int RADIUS_BITS_DEF = 11;

	// Fixed result widths
	localparam int OUT_BITS    = 14;
	localparam int COLOUR_BITS = 32;

	// Group queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Input op codes
	localparam logic OP_START = 1'b0;

	// Config port: byte address width and register index
	localparam int   PADDR_BITS    = 3;
	localparam logic REG_FILL_MODE = 1'b0;

	// Result index within a group
	localparam int            K_BITS      = 3;
	localparam logic [K_BITS-1:0] K_FIRST     = 3'd0;
	localparam logic [K_BITS-1:0] K_LAST_LINE = 3'd7;
	localparam logic [K_BITS-1:0] K_LAST_FILL = 3'd6;
	localparam logic [K_BITS-1:0] K_STEP_LINE = 3'd1;
	localparam logic [K_BITS-1:0] K_STEP_FILL = 3'd2;

	// Operand selection for one result of a group
	typedef struct packed {
		logic x_use_b;   // column offset is b instead of a
		logic x_neg;     // column offset is subtracted
		logic row_use_a; // row offset is a instead of b
		logic row_neg;   // row offset is subtracted
	} oct_sel_t;

	// Octant order: (+a,+b) (-a,+b) (+b,+a) (-b,+a) (-b,-a) (+b,-a) (+a,-b) (-a,-b).
	// Fill mode walks the even entries and mirrors the span end.
	function automatic oct_sel_t crast_sel(input logic [K_BITS-1:0] k);
		oct_sel_t s;
		case (k)
			3'd0: s = '{x_use_b: 1'b0, x_neg: 1'b0, row_use_a: 1'b0, row_neg: 1'b0};
			3'd1: s = '{x_use_b: 1'b0, x_neg: 1'b1, row_use_a: 1'b0, row_neg: 1'b0};
			3'd2: s = '{x_use_b: 1'b1, x_neg: 1'b0, row_use_a: 1'b1, row_neg: 1'b0};
			3'd3: s = '{x_use_b: 1'b1, x_neg: 1'b1, row_use_a: 1'b1, row_neg: 1'b0};
			3'd4: s = '{x_use_b: 1'b1, x_neg: 1'b1, row_use_a: 1'b1, row_neg: 1'b1};
			3'd5: s = '{x_use_b: 1'b1, x_neg: 1'b0, row_use_a: 1'b1, row_neg: 1'b1};
			3'd6: s = '{x_use_b: 1'b0, x_neg: 1'b0, row_use_a: 1'b0, row_neg: 1'b1};
			3'd7: s = '{x_use_b: 1'b0, x_neg: 1'b1, row_use_a: 1'b0, row_neg: 1'b1};
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

>>> hw/rtl/crast_queue.sv
// ----------------------------------------------------------------------------
// crast_queue
// Small register FIFO holding pending octant groups between front and back.
// ----------------------------------------------------------------------------
module crast_queue import crast_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);
	localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full      = (count_q == CNT_FULL);
	assign empty     = (count_q == '0);
	assign head_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

endmodule

>>> hw/rtl/crast_front.sv
// ----------------------------------------------------------------------------
// crast_front
// Accepts start/step items, holds the midpoint state, and queues one octant
// group (centre, point, colour, mode, done flag) per drawing item.
// ----------------------------------------------------------------------------
module crast_front import crast_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int RADIUS_BITS = RADIUS_BITS_DEF,
	parameter int DESC_BITS   = 2 * COORD_BITS + 2 * (RADIUS_BITS + 2) + COLOUR_BITS + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic                   op,
	input  logic [COORD_BITS-1:0]  centre_x,
	input  logic [COORD_BITS-1:0]  centre_y,
	input  logic [RADIUS_BITS-1:0] radius,
	input  logic [COLOUR_BITS-1:0] colour,
	input  logic                   fill_mode,
	input  logic                   q_full,
	output logic                   q_push,
	output logic [DESC_BITS-1:0]   q_data
);

	localparam int A_BITS = RADIUS_BITS + 2;
	localparam int S_BITS = RADIUS_BITS + 2;
	localparam int E_BITS = RADIUS_BITS + 3;
	localparam logic signed [A_BITS-1:0] A_ONE  = A_BITS'(1);
	localparam logic        [S_BITS-1:0] S_ONE  = S_BITS'(1);
	localparam logic        [S_BITS-1:0] S_TWO  = S_BITS'(2);
	localparam logic signed [E_BITS-1:0] E_ONE  = E_BITS'(1);
	localparam logic signed [E_BITS-1:0] E_ZERO = '0;

	// circle state
	logic                     active_q;
	logic [COORD_BITS-1:0]    cx_q, cy_q;
	logic [RADIUS_BITS-1:0]   r_q;
	logic [COLOUR_BITS-1:0]   colour_q;
	logic signed [A_BITS-1:0] a_q, b_q;
	logic [S_BITS-1:0]        sm_q, sn_q;
	logic signed [E_BITS-1:0] e_q;

	// state as seen by this item
	logic                     start, accept, cur_active;
	logic [COORD_BITS-1:0]    cur_cx, cur_cy;
	logic [RADIUS_BITS-1:0]   cur_r;
	logic [COLOUR_BITS-1:0]   cur_colour;
	logic signed [A_BITS-1:0] cur_a, cur_b;
	logic [S_BITS-1:0]        cur_sm, cur_sn;
	logic signed [E_BITS-1:0] cur_e, two_r;

	// advanced state
	logic signed [A_BITS-1:0] a_n, b_n;
	logic [S_BITS-1:0]        sm_n, sn_n, sm_inc;
	logic signed [E_BITS-1:0] e_n;
	logic                     done;

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;
	assign start      = (op == OP_START);

	// a start item overrides the held state
	always_comb begin
		cur_cx     = start ? centre_x : cx_q;
		cur_cy     = start ? centre_y : cy_q;
		cur_r      = start ? radius   : r_q;
		cur_colour = start ? colour   : colour_q;
		cur_a      = start ? ($signed({2'b00, radius}) - A_ONE) : a_q;
		cur_b      = start ? '0 : b_q;
		cur_sm     = start ? S_ONE : sm_q;
		cur_sn     = start ? S_ONE : sn_q;
		cur_e      = start ? (E_ONE - $signed({2'b00, radius, 1'b0})) : e_q;
		cur_active = start ? (radius != '0) : active_q;
	end

	assign two_r  = $signed({2'b00, cur_r, 1'b0});
	assign sm_inc = cur_sm + S_TWO;

	// midpoint advance: one axis moves
	always_comb begin
		a_n  = cur_a;
		b_n  = cur_b;
		sm_n = cur_sm;
		sn_n = cur_sn;
		if (cur_e <= E_ZERO) begin
			b_n  = cur_b + A_ONE;
			e_n  = cur_e + $signed({1'b0, cur_sn});
			sn_n = cur_sn + S_TWO;
		end else begin
			a_n  = cur_a - A_ONE;
			sm_n = sm_inc;
			e_n  = cur_e + $signed({1'b0, sm_inc}) - two_r;
		end
	end

	assign done   = (a_n < b_n);
	assign q_push = accept && cur_active;
	assign q_data = {cur_cx, cur_cy, cur_a, cur_b, cur_colour, fill_mode, done};

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
			r_q      <= '0;
			colour_q <= '0;
			a_q      <= '0;
			b_q      <= '0;
			sm_q     <= S_ONE;
			sn_q     <= S_ONE;
			e_q      <= '0;
		end else if (accept) begin
			if (start) begin
				cx_q     <= centre_x;
				cy_q     <= centre_y;
				r_q      <= radius;
				colour_q <= colour;
			end
			if (cur_active) begin
				active_q <= !done;
				a_q      <= a_n;
				b_q      <= b_n;
				sm_q     <= sm_n;
				sn_q     <= sn_n;
				e_q      <= e_n;
			end else begin
				active_q <= 1'b0;
				a_q      <= cur_a;
				b_q      <= cur_b;
				sm_q     <= cur_sm;
				sn_q     <= cur_sn;
				e_q      <= cur_e;
			end
		end
	end

endmodule

>>> hw/rtl/crast_back.sv
// ----------------------------------------------------------------------------
// crast_back
// Expands the queued group at the head into eight pixels or four spans, one
// result per cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module crast_back import crast_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int RADIUS_BITS = RADIUS_BITS_DEF,
	parameter int DESC_BITS   = 2 * COORD_BITS + 2 * (RADIUS_BITS + 2) + COLOUR_BITS + 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  logic [DESC_BITS-1:0]       q_data,
	output logic                       q_pop,
	output logic                       pix_valid,
	input  logic                       pix_ready,
	output logic signed [OUT_BITS-1:0] x_start,
	output logic signed [OUT_BITS-1:0] x_end,
	output logic signed [OUT_BITS-1:0] row,
	output logic [COLOUR_BITS-1:0]     pixel_colour,
	output logic                       group_last,
	output logic                       circle_done
);

	localparam int A_BITS   = RADIUS_BITS + 2;
	localparam int W0       = (COORD_BITS + 1 > A_BITS) ? COORD_BITS + 1 : A_BITS;
	localparam int CALC_BITS = ((W0 > OUT_BITS) ? W0 : OUT_BITS) + 1;

	// group fields
	logic [COORD_BITS-1:0]    d_cx, d_cy;
	logic signed [A_BITS-1:0] d_a, d_b;
	logic [COLOUR_BITS-1:0]   d_colour;
	logic                     d_fill, d_done;

	logic [K_BITS-1:0]           k_q;
	logic                        last, adv;
	oct_sel_t                    sel;
	logic signed [CALC_BITS-1:0] cx_c, cy_c, a_c, b_c, x_off, row_off;
	logic signed [CALC_BITS-1:0] x_plus, x_minus, xs_c, xe_c, row_c;

	assign {d_cx, d_cy, d_a, d_b, d_colour, d_fill, d_done} = q_data;

	// operand select and coordinate adders
	assign sel     = crast_sel(k_q);
	assign cx_c    = $signed(CALC_BITS'(d_cx));
	assign cy_c    = $signed(CALC_BITS'(d_cy));
	assign a_c     = CALC_BITS'(d_a);
	assign b_c     = CALC_BITS'(d_b);
	assign x_off   = sel.x_use_b ? b_c : a_c;
	assign row_off = sel.row_use_a ? a_c : b_c;
	assign x_plus  = cx_c + x_off;
	assign x_minus = cx_c - x_off;
	assign xs_c    = sel.x_neg ? x_minus : x_plus;
	assign xe_c    = (sel.x_neg ^ d_fill) ? x_minus : x_plus;
	assign row_c   = sel.row_neg ? (cy_c - row_off) : (cy_c + row_off);

	assign last  = d_fill ? (k_q == K_LAST_FILL) : (k_q == K_LAST_LINE);
	assign adv   = !q_empty && (!pix_valid || pix_ready);
	assign q_pop = adv && last;

	// result index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= K_FIRST;
			pix_valid <= 1'b0;
		end else begin
			if (adv) begin
				k_q <= last ? K_FIRST : (k_q + (d_fill ? K_STEP_FILL : K_STEP_LINE));
			end
			if (adv) begin
				pix_valid <= 1'b1;
			end else if (pix_ready) begin
				pix_valid <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv) begin
			x_start      <= xs_c[OUT_BITS-1:0];
			x_end        <= xe_c[OUT_BITS-1:0];
			row          <= row_c[OUT_BITS-1:0];
			pixel_colour <= d_colour;
			group_last   <= last;
			circle_done  <= d_done;
		end
	end

endmodule

>>> hw/rtl/circle_rasterizer_top.sv
// ----------------------------------------------------------------------------
// circle_rasterizer_top
// Midpoint circle rasterizer with an APB fill-mode register.
// ----------------------------------------------------------------------------
// A start item (op 0) loads centre, radius and colour and draws the first
// octant group; each step item (op 1) draws the next group until the group
// flagged circle_done. Outline mode gives eight pixels per group, fill mode
// four horizontal spans. The front accepts one item per cycle while the
// four-entry group queue has room; the back emits one result per cycle
// while the output is not stalled. A zero-radius start or an idle step
// gives no output. The first result of an item passes through the group
// queue and then the registered output stage. Coordinates wrap to 14 bits;
// no clipping is done.
module circle_rasterizer_top import crast_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// config port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [PADDR_BITS-1:0]      paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// item channel
	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic                       op,
	input  logic [COORD_BITS-1:0]      centre_x,
	input  logic [COORD_BITS-1:0]      centre_y,
	input  logic [RADIUS_BITS-1:0]     radius,
	input  logic [COLOUR_BITS-1:0]     colour,
	// result channel
	output logic                       pix_valid,
	input  logic                       pix_ready,
	output logic signed [OUT_BITS-1:0] x_start,
	output logic signed [OUT_BITS-1:0] x_end,
	output logic signed [OUT_BITS-1:0] row,
	output logic [COLOUR_BITS-1:0]     pixel_colour,
	output logic                       group_last,
	output logic                       circle_done
);

	localparam int DESC_BITS = 2 * COORD_BITS + 2 * (RADIUS_BITS + 2) + COLOUR_BITS + 2;

	logic                 fill_mode_q;
	logic                 reg_hit;
	logic                 q_push, q_pop, q_full, q_empty;
	logic [DESC_BITS-1:0] q_wdata, q_rdata;

	// config register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_BITS-1:2] == REG_FILL_MODE);
	assign prdata  = reg_hit ? {31'b0, fill_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			fill_mode_q <= pwdata[0];
		end
	end

	crast_front #(
		.COORD_BITS (COORD_BITS),
		.RADIUS_BITS(RADIUS_BITS),
		.DESC_BITS  (DESC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.op        (op),
		.centre_x  (centre_x),
		.centre_y  (centre_y),
		.radius    (radius),
		.colour    (colour),
		.fill_mode (fill_mode_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	crast_queue #(
		.WIDTH(DESC_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.head_data(q_rdata),
		.empty    (q_empty)
	);

	crast_back #(
		.COORD_BITS (COORD_BITS),
		.RADIUS_BITS(RADIUS_BITS),
		.DESC_BITS  (DESC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.x_start     (x_start),
		.x_end       (x_end),
		.row         (row),
		.pixel_colour(pixel_colour),
		.group_last  (group_last),
		.circle_done (circle_done)
	);

endmodule

>>> hw/rtl/crast_checker.sv
// ----------------------------------------------------------------------------
// crast_checker
// Port-level checks on the result channel of the circle rasterizer.
// ----------------------------------------------------------------------------
module crast_checker import crast_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pix_valid,
	input logic                       pix_ready,
	input logic signed [OUT_BITS-1:0] x_start,
	input logic signed [OUT_BITS-1:0] x_end,
	input logic signed [OUT_BITS-1:0] row,
	input logic [COLOUR_BITS-1:0]     pixel_colour,
	input logic                       group_last,
	input logic                       circle_done
);

	// stalled result holds
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid)
		else $error("result dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> $stable(x_start) && $stable(x_end) && $stable(row)
			&& $stable(pixel_colour) && $stable(group_last) && $stable(circle_done))
		else $error("result changed while stalled");

	// a group streams without gaps and shares colour and done flag
	a_group_cont: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && !group_last |=>
			pix_valid && pixel_colour == $past(pixel_colour)
			&& circle_done == $past(circle_done))
		else $error("group broken");

	// spans of one group are centred on the same column
	a_span_centre: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && !group_last && x_start != x_end |=>
			OUT_BITS'(x_start + x_end) == $past(OUT_BITS'(x_start + x_end)))
		else $error("span centre moved within group");

endmodule

bind circle_rasterizer_top crast_checker u_crast_checker (.*);

>>> verif/circle_rasterizer_checker.sv
// ----------------------------------------------------------------------------
// circle_rasterizer_checker
// Watches the config port and both channels of the circle rasterizer, keeps
// its own midpoint circle state and queues the pixels or spans that each item
// transfer must produce. Every result transfer is compared field by field
// with the oldest queued result; register reads are checked as well.
// ----------------------------------------------------------------------------
module circle_rasterizer_checker import crast_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [PADDR_BITS-1:0]          paddr,
	input  logic [31:0]                    pwdata,
	input  logic [31:0]                    prdata,
	input  logic                           pready,
	input  logic                           item_valid,
	input  logic                           item_ready,
	input  logic                           op,
	input  logic [COORD_BITS_DEF-1:0]      centre_x,
	input  logic [COORD_BITS_DEF-1:0]      centre_y,
	input  logic [RADIUS_BITS_DEF-1:0]     radius,
	input  logic [COLOUR_BITS-1:0]         colour,
	input  logic                           pix_valid,
	input  logic                           pix_ready,
	input  logic signed [OUT_BITS-1:0]     x_start,
	input  logic signed [OUT_BITS-1:0]     x_end,
	input  logic signed [OUT_BITS-1:0]     row,
	input  logic [COLOUR_BITS-1:0]         pixel_colour,
	input  logic                           group_last,
	input  logic                           circle_done,
	output int                             fail_count,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PADDR_BITS-1:0] FILL_ADDR = PADDR_BITS'(4 * REG_FILL_MODE);

	typedef struct {
		logic signed [OUT_BITS-1:0] xs;
		logic signed [OUT_BITS-1:0] xe;
		logic signed [OUT_BITS-1:0] rw;
		logic [COLOUR_BITS-1:0]     colour;
		logic                       last;
		logic                       done;
	} pix_t;

	pix_t pix_expect_q[$];

	// circle walker state
	logic                   fill_on;
	logic                   drawing;
	int                     ctr_col;
	int                     ctr_row;
	int                     rad;
	logic [COLOUR_BITS-1:0] col_word;
	int                     maj;
	int                     mnr;
	int                     inc_maj;
	int                     inc_mnr;
	int                     err;

	initial fail_count = 0;

	task automatic report(input string msg);
		if (fail_count < 10)
			$display("%s", msg);
		fail_count++;
	endtask

	// one result; coordinates wrap to the output width
	function automatic pix_t make_pix(input int xs, input int xe, input int rw);
		pix_t p;
		p.xs     = OUT_BITS'(xs);
		p.xe     = OUT_BITS'(xe);
		p.rw     = OUT_BITS'(rw);
		p.colour = col_word;
		p.last   = 1'b0;
		p.done   = 1'b0;
		return p;
	endfunction

	// emit the group for the current point, then move one axis
	task automatic draw_group();
		pix_t grp[8];
		int   n;
		if (!drawing)
			return;
		if (fill_on) begin
			grp[0] = make_pix(ctr_col + maj, ctr_col - maj, ctr_row + mnr);
			grp[1] = make_pix(ctr_col + mnr, ctr_col - mnr, ctr_row + maj);
			grp[2] = make_pix(ctr_col - mnr, ctr_col + mnr, ctr_row - maj);
			grp[3] = make_pix(ctr_col + maj, ctr_col - maj, ctr_row - mnr);
			n = 4;
		end else begin
			grp[0] = make_pix(ctr_col + maj, ctr_col + maj, ctr_row + mnr);
			grp[1] = make_pix(ctr_col - maj, ctr_col - maj, ctr_row + mnr);
			grp[2] = make_pix(ctr_col + mnr, ctr_col + mnr, ctr_row + maj);
			grp[3] = make_pix(ctr_col - mnr, ctr_col - mnr, ctr_row + maj);
			grp[4] = make_pix(ctr_col - mnr, ctr_col - mnr, ctr_row - maj);
			grp[5] = make_pix(ctr_col + mnr, ctr_col + mnr, ctr_row - maj);
			grp[6] = make_pix(ctr_col + maj, ctr_col + maj, ctr_row - mnr);
			grp[7] = make_pix(ctr_col - maj, ctr_col - maj, ctr_row - mnr);
			n = 8;
		end
		if (err <= 0) begin
			mnr++;
			err += inc_mnr;
			inc_mnr += 2;
		end else begin
			maj--;
			inc_maj += 2;
			err += inc_maj - 2 * rad;
		end
		if (maj < mnr) begin
			drawing = 1'b0;
			for (int k = 0; k < n; k++)
				grp[k].done = 1'b1;
		end
		grp[n-1].last = 1'b1;
		for (int k = 0; k < n; k++)
			pix_expect_q.push_back(grp[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pix_t e;
		if (!arst_n) begin
			pix_expect_q.delete();
			fill_on  = 1'b0;
			drawing  = 1'b0;
			ctr_col  = 0;
			ctr_row  = 0;
			rad      = 0;
			col_word = '0;
			maj      = 0;
			mnr      = 0;
			inc_maj  = 1;
			inc_mnr  = 1;
			err      = 0;
			outstanding <= 0;
		end else begin
			// result transfer against the oldest expectation
			if (pix_valid && pix_ready) begin
				if (pix_expect_q.size() == 0) begin
					report($sformatf({"unexpected result: x %0d..%0d row %0d colour %h",
						" last %b done %b"}, x_start, x_end, row, pixel_colour,
						group_last, circle_done));
				end else begin
					e = pix_expect_q.pop_front();
					if (x_start !== e.xs || x_end !== e.xe || row !== e.rw ||
						pixel_colour !== e.colour || group_last !== e.last ||
						circle_done !== e.done) begin
						report($sformatf({"result mismatch: expected x %0d..%0d row %0d",
							" colour %h last %b done %b, got x %0d..%0d row %0d",
							" colour %h last %b done %b"},
							e.xs, e.xe, e.rw, e.colour, e.last, e.done,
							x_start, x_end, row, pixel_colour, group_last, circle_done));
					end
				end
			end

			// item transfer: a start reloads the walker, then one group is drawn
			if (item_valid && item_ready) begin
				if (op == OP_START) begin
					ctr_col  = int'(centre_x);
					ctr_row  = int'(centre_y);
					rad      = int'(radius);
					col_word = colour;
					maj      = rad - 1;
					mnr      = 0;
					inc_maj  = 1;
					inc_mnr  = 1;
					err      = 1 - 2 * rad;
					drawing  = (maj >= mnr);
				end
				draw_group();
			end

			// config port
			if (psel && penable && pready && paddr == FILL_ADDR) begin
				if (pwrite)
					fill_on = pwdata[0];
				else if (prdata !== 32'(fill_on))
					report($sformatf("fill_mode read: expected %h, got %h",
						32'(fill_on), prdata));
			end

			outstanding <= pix_expect_q.size();
		end
	end

endmodule

>>> verif/tb_circle_rasterizer_top.sv
// ----------------------------------------------------------------------------
// tb_circle_rasterizer_top
// Drives the circle rasterizer with directed corner circles and then random
// circle sequences in outline and fill mode, with random stalls on both
// channels. The checker beside the block predicts and compares every result;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_circle_rasterizer_top import crast_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int   CYCLE_LIMIT = 300000;
	localparam logic OP_STEP     = ~OP_START;
	localparam logic [PADDR_BITS-1:0] FILL_ADDR = PADDR_BITS'(4 * REG_FILL_MODE);
	localparam logic [COORD_BITS_DEF-1:0]  COORD_MAX  = '1;
	localparam logic [RADIUS_BITS_DEF-1:0] RADIUS_MAX = '1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                        psel    = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite  = 1'b0;
	logic [PADDR_BITS-1:0]       paddr   = '0;
	logic [31:0]                 pwdata  = '0;
	logic [31:0]                 prdata;
	logic                        pready;

	logic                        item_valid = 1'b0;
	logic                        item_ready;
	logic                        op         = 1'b0;
	logic [COORD_BITS_DEF-1:0]   centre_x   = '0;
	logic [COORD_BITS_DEF-1:0]   centre_y   = '0;
	logic [RADIUS_BITS_DEF-1:0]  radius     = '0;
	logic [COLOUR_BITS-1:0]      colour     = '0;

	logic                        pix_valid;
	logic                        pix_ready  = 1'b0;
	logic signed [OUT_BITS-1:0]  x_start;
	logic signed [OUT_BITS-1:0]  x_end;
	logic signed [OUT_BITS-1:0]  row;
	logic [COLOUR_BITS-1:0]      pixel_colour;
	logic                        group_last;
	logic                        circle_done;

	int   fail_count;
	int   outstanding;
	int   cycles   = 0;
	logic no_idle  = 1'b0;
	int   items_sent;

	always #5 clk = ~clk;

	circle_rasterizer_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.op           (op),
		.centre_x     (centre_x),
		.centre_y     (centre_y),
		.radius       (radius),
		.colour       (colour),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.x_start      (x_start),
		.x_end        (x_end),
		.row          (row),
		.pixel_colour (pixel_colour),
		.group_last   (group_last),
		.circle_done  (circle_done)
	);

	circle_rasterizer_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.op           (op),
		.centre_x     (centre_x),
		.centre_y     (centre_y),
		.radius       (radius),
		.colour       (colour),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.x_start      (x_start),
		.x_end        (x_end),
		.row          (row),
		.pixel_colour (pixel_colour),
		.group_last   (group_last),
		.circle_done  (circle_done),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// pixel sink stalls about 30% of cycles outside the no-idle stretch
	always @(posedge clk)
		pix_ready <= no_idle || ($urandom_range(99) >= 30);

	// one item transfer, after a random gap
	task automatic send_item(input logic o, input logic [COORD_BITS_DEF-1:0] x,
		input logic [COORD_BITS_DEF-1:0] y, input logic [RADIUS_BITS_DEF-1:0] r,
		input logic [COLOUR_BITS-1:0] c);
		while (!no_idle && $urandom_range(99) < 30) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		op         <= o;
		centre_x   <= x;
		centre_y   <= y;
		radius     <= r;
		colour     <= c;
		do @(posedge clk); while (!item_ready);
	endtask

	// step item with junk in the unused fields
	task automatic junk_step();
		send_item(OP_STEP, COORD_BITS_DEF'($urandom), COORD_BITS_DEF'($urandom),
			RADIUS_BITS_DEF'($urandom), $urandom);
	endtask

	// start item plus a number of step items
	task automatic draw_circle(input logic [COORD_BITS_DEF-1:0] x,
		input logic [COORD_BITS_DEF-1:0] y, input logic [RADIUS_BITS_DEF-1:0] r,
		input logic [COLOUR_BITS-1:0] c, input int steps);
		send_item(OP_START, x, y, r, c);
		repeat (steps)
			junk_step();
		items_sent += 1 + steps;
	endtask

	task automatic lone_step();
		junk_step();
	endtask

	// drain all results, then leave room for an item still in flight
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write fill_mode, then read it back
	task automatic set_fill(input logic v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= FILL_ADDR;
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [COORD_BITS_DEF-1:0] pick_coord();
		if ($urandom_range(99) < 25)
			return $urandom_range(1) ? COORD_MAX : '0;
		return COORD_BITS_DEF'($urandom_range(COORD_MAX));
	endfunction

	// mostly complete small circles; a radius r circle takes r groups
	task automatic run_random(input int target);
		int kind;
		int r;
		int n;
		items_sent = 0;
		while (items_sent < target) begin
			kind = $urandom_range(99);
			if (kind >= 93) begin
				lone_step();
			end else begin
				if (kind < 60) begin
					r = $urandom_range(1, 12);
					n = r - 1;
				end else if (kind < 68) begin
					r = $urandom_range(13, 48);
					n = r - 1;
				end else if (kind < 78) begin
					r = $urandom_range(2, 12);
					n = $urandom_range(0, r - 2);
				end else if (kind < 86) begin
					r = $urandom_range(RADIUS_MAX);
					n = $urandom_range(0, 6);
				end else begin
					r = 0;
					n = 0;
				end
				draw_circle(pick_coord(), pick_coord(), RADIUS_BITS_DEF'(r), $urandom, n);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, outline mode from reset
		lone_step();
		draw_circle(COORD_MAX, '0, '0, 32'h1234_5678, 0);
		draw_circle('0, '0, RADIUS_BITS_DEF'(1), '0, 0);
		draw_circle(COORD_MAX, COORD_MAX, RADIUS_BITS_DEF'(2), '1, 1);
		draw_circle('0, COORD_MAX, RADIUS_MAX, 32'hA5A5_5A5A, 2);
		draw_circle(COORD_MAX, '0, RADIUS_MAX, 32'h5A5A_A5A5, 1);
		draw_circle(12'd100, 12'd200, RADIUS_BITS_DEF'(5), 32'hDEAD_BEEF, 4);
		lone_step();
		settle();

		// directed, fill mode
		set_fill(1'b1);
		draw_circle('0, COORD_MAX, RADIUS_BITS_DEF'(1), '1, 0);
		draw_circle(12'd7, 12'd9, RADIUS_BITS_DEF'(3), 32'h0F0F_F0F0, 2);
		draw_circle(COORD_MAX, COORD_MAX, '0, '0, 0);
		lone_step();
		draw_circle(COORD_MAX, '0, RADIUS_MAX, 32'hCAFE_F00D, 1);
		settle();

		// random phases across both settings, one without any idling
		set_fill(1'b0);
		run_random(75);
		settle();
		set_fill(1'b1);
		run_random(75);
		settle();
		set_fill(1'b0);
		no_idle = 1'b1;
		run_random(75);
		settle();
		no_idle = 1'b0;
		set_fill(1'b1);
		run_random(75);
		settle();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> circle_rasterizer_top.f
hw/rtl/crast_pkg.sv
hw/rtl/crast_queue.sv
hw/rtl/crast_front.sv
hw/rtl/crast_back.sv
hw/rtl/circle_rasterizer_top.sv
hw/rtl/crast_checker.sv
verif/circle_rasterizer_checker.sv
verif/tb_circle_rasterizer_top.sv
